FILE: design/lewr_pkg.sv
package lewr_pkg;

    // line geometry
    localparam int LINE_WIDTH = 40;
    localparam int CUR_W      = $clog2(LINE_WIDTH + 1);
    localparam int ADDR_W     = $clog2(LINE_WIDTH);

    // field widths
    localparam int BYTE_W    = 8;
    localparam int CHAR_W    = 7;
    localparam int CNT_W     = 6;
    localparam int ACT_W     = 3;
    localparam int CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KILL       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_ERASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EOT        = 3'd3;

    // register reset values
    localparam logic [BYTE_W-1:0] ERASE_RST      = 8'd127;
    localparam logic [BYTE_W-1:0] KILL_RST       = 8'd21;
    localparam logic [BYTE_W-1:0] WORD_ERASE_RST = 8'd23;
    localparam logic [BYTE_W-1:0] EOT_RST        = 8'd4;

    // character codes
    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;
    localparam logic [BYTE_W-1:0] PRINT_LO     = 8'd32;
    localparam logic [BYTE_W-1:0] PRINT_HI     = 8'd126;
    localparam logic [CHAR_W-1:0] SPACE_CHAR   = 7'd32;

    typedef enum logic [ACT_W-1:0] {
        ACT_ECHO    = 3'd0,
        ACT_NEWLINE = 3'd1,
        ACT_ERASE   = 3'd2,
        ACT_BELL    = 3'd3,
        ACT_END     = 3'd4
    } t_action;

    typedef struct packed {
        t_action            action;
        logic [BYTE_W-1:0]  char_value;
        logic [CNT_W-1:0]   erase_count;
        logic               last;
    } t_result;

endpackage

FILE: design/lewr_in_if.sv
interface lewr_in_if import lewr_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] key_byte;

    modport source (output valid, output key_byte, input ready);
    modport sink   (input valid, input key_byte, output ready);

endinterface

FILE: design/lewr_out_if.sv
interface lewr_out_if import lewr_pkg::*; ();

    logic              valid;
    logic              ready;
    t_action           action;
    logic [BYTE_W-1:0] char_value;
    logic [CNT_W-1:0]  erase_count;
    logic              last;

    modport source (output valid, output action, output char_value, output erase_count,
                    output last, input ready);
    modport sink   (input valid, input action, input char_value, input erase_count,
                    input last, output ready);

endinterface

FILE: design/lewr_ram.sv
module lewr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/line_editor_word_wrap.sv
// Raw-mode line editor with word wrap. One key byte is taken per input beat and
// answered with zero or more action beats (echo, newline, erase run, bell, end of
// input), the final one flagged by last. The typed line lives in a single
// LINE_WIDTH x 7 RAM with a registered read; the cursor, the ended flag and the
// four control-character registers are flip-flops. Bytes are taken one at a
// time: the input is ready only while the sequencer is idle, but a finished
// result waiting in the output register does not hold off the next byte.
// Word erase walks the line one RAM entry per cycle. A wrap scans back from the
// line end for a space, one entry per cycle, then copies and echoes the moved
// word one character per cycle while the output is not stalled.
// Control registers may be written at any time the block is idle; the RAM needs
// no clearing after reset since only entries already written are ever used.
module line_editor_word_wrap import lewr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    lewr_in_if.sink              i_key,
    lewr_out_if.source           o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT,
        S_WSP,
        S_WNS,
        S_WR_SCAN,
        S_WR_ERASE,
        S_WR_NL,
        S_WR_CP
    } t_state;

    localparam logic [CUR_W-1:0] LW_C = CUR_W'(LINE_WIDTH);

    // control-character registers
    logic [BYTE_W-1:0] r_erase_char;
    logic [BYTE_W-1:0] r_kill_char;
    logic [BYTE_W-1:0] r_word_erase_char;
    logic [BYTE_W-1:0] r_eot_char;

    // sequencer state
    t_state            r_state, n_state;
    logic [CUR_W-1:0]  r_cursor, n_cursor;
    logic              r_ended, n_ended;
    logic [CUR_W-1:0]  r_p, n_p;       // scan / read pointer, data is entry r_p-1
    logic [CUR_W-1:0]  r_n, n_n;       // length of the word moved on wrap
    logic [CUR_W-1:0]  r_i, n_i;       // copy destination index
    logic              r_wrap, n_wrap; // wrap follows the pending echo
    t_result           r_pend, n_pend; // single result waiting to be sent

    // output register
    logic              r_out_valid;
    t_result           r_out;
    logic              out_free;
    logic              emit;
    t_result           emit_res;

    // line store port signals
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;
    logic [CUR_W-1:0]  rd_ptr;

    logic [BYTE_W-1:0] key;
    logic              is_print;
    logic [CUR_W-1:0]  cur_inc;
    logic [CUR_W-1:0]  wrap_len;
    logic              cp_last;

    assign out_free = !r_out_valid || o_res.ready;
    assign key      = i_key.key_byte;
    assign is_print = (key >= PRINT_LO) && (key <= PRINT_HI);
    assign cur_inc  = r_cursor + 1'b1;
    assign wrap_len = LW_C - r_p;
    assign cp_last  = (r_i == r_n - 1'b1);

    // byte taken only when idle
    assign i_key.ready = (r_state == S_IDLE);

    lewr_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LINE_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_cursor  = r_cursor;
        n_ended   = r_ended;
        n_p       = r_p;
        n_n       = r_n;
        n_i       = r_i;
        n_wrap    = r_wrap;
        n_pend    = r_pend;
        emit      = 1'b0;
        emit_res  = r_pend;
        ram_we    = 1'b0;
        ram_waddr = r_cursor[ADDR_W-1:0];
        ram_wdata = key[CHAR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                // bytes after end of input are swallowed
                if (i_key.valid && !r_ended) begin
                    n_wrap = 1'b0;
                    n_pend = '{action: ACT_BELL, char_value: '0, erase_count: '0,
                               last: 1'b1};
                    if (key == NEWLINE_BYTE) begin
                        n_pend.action     = ACT_NEWLINE;
                        n_pend.char_value = NEWLINE_BYTE;
                        n_cursor          = '0;
                        n_state           = S_EMIT;
                    end else if (is_print) begin
                        // store and echo; a full line then wraps
                        ram_we            = 1'b1;
                        n_cursor          = cur_inc;
                        n_pend.action     = ACT_ECHO;
                        n_pend.char_value = key;
                        n_pend.last       = (cur_inc != LW_C);
                        n_wrap            = (cur_inc == LW_C);
                        n_p               = LW_C;
                        n_state           = S_EMIT;
                    end else if (key == r_erase_char) begin
                        if (r_cursor != '0) begin
                            n_pend.action      = ACT_ERASE;
                            n_pend.erase_count = CNT_W'(1);
                            n_cursor           = r_cursor - 1'b1;
                            n_state            = S_EMIT;
                        end
                    end else if (key == r_kill_char) begin
                        if (r_cursor != '0) begin
                            n_pend.action      = ACT_ERASE;
                            n_pend.erase_count = CNT_W'(r_cursor);
                            n_cursor           = '0;
                            n_state            = S_EMIT;
                        end
                    end else if (key == r_word_erase_char) begin
                        n_p     = r_cursor;
                        n_state = S_WSP;
                    end else if (key == r_eot_char) begin
                        if (r_cursor == '0) begin
                            n_pend.action = ACT_END;
                            n_ended       = 1'b1;
                            n_state       = S_EMIT;
                        end
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = r_wrap ? S_WR_SCAN : S_IDLE;
                end
            end

            // word erase: trailing spaces first, a line of spaces alone still erases
            S_WSP: begin
                if (r_p != '0 && ram_rdata == SPACE_CHAR) begin
                    n_p = r_p - 1'b1;
                end else begin
                    n_state = S_WNS;
                end
            end

            // word erase: then the word itself
            S_WNS: begin
                if (r_p != '0 && ram_rdata != SPACE_CHAR) begin
                    n_p = r_p - 1'b1;
                end else if (r_p < r_cursor) begin
                    n_pend = '{action: ACT_ERASE, char_value: '0,
                               erase_count: CNT_W'(r_cursor - r_p), last: 1'b1};
                    n_cursor = r_p;
                    n_wrap   = 1'b0;
                    n_state  = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end

            // wrap: look back from the line end for a space
            S_WR_SCAN: begin
                if (r_p != '0 && ram_rdata != SPACE_CHAR) begin
                    n_p = r_p - 1'b1;
                end else if (r_p == '0 || wrap_len == '0) begin
                    // no word to move, plain line break
                    n_pend = '{action: ACT_NEWLINE, char_value: NEWLINE_BYTE,
                               erase_count: '0, last: 1'b1};
                    n_cursor = '0;
                    n_wrap   = 1'b0;
                    n_state  = S_EMIT;
                end else begin
                    n_n      = wrap_len;
                    n_cursor = wrap_len;
                    n_i      = '0;
                    n_p      = r_p + 1'b1;
                    n_wrap   = 1'b0;
                    n_state  = S_WR_ERASE;
                end
            end

            S_WR_ERASE: begin
                if (out_free) begin
                    emit     = 1'b1;
                    emit_res = '{action: ACT_ERASE, char_value: '0,
                                 erase_count: CNT_W'(r_n), last: 1'b0};
                    n_state  = S_WR_NL;
                end
            end

            S_WR_NL: begin
                if (out_free) begin
                    emit     = 1'b1;
                    emit_res = '{action: ACT_NEWLINE, char_value: NEWLINE_BYTE,
                                 erase_count: '0, last: 1'b0};
                    n_state  = S_WR_CP;
                end
            end

            // move the word to the line start and echo it, one char per beat
            S_WR_CP: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_res  = '{action: ACT_ECHO, char_value: {1'b0, ram_rdata},
                                  erase_count: '0, last: cp_last};
                    ram_we    = 1'b1;
                    ram_waddr = r_i[ADDR_W-1:0];
                    ram_wdata = ram_rdata;
                    n_i       = r_i + 1'b1;
                    n_p       = r_p + 1'b1;
                    if (cp_last) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase

        // read ahead so the entry below the next pointer is ready next cycle
        rd_ptr = n_p - 1'b1;
        if (n_p == '0 || n_p > LW_C) begin
            ram_raddr = '0;
        end else begin
            ram_raddr = rd_ptr[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_cursor          <= '0;
            r_ended           <= 1'b0;
            r_wrap            <= 1'b0;
            r_out_valid       <= 1'b0;
            r_erase_char      <= ERASE_RST;
            r_kill_char       <= KILL_RST;
            r_word_erase_char <= WORD_ERASE_RST;
            r_eot_char        <= EOT_RST;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_ended  <= n_ended;
            r_wrap   <= n_wrap;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ERASE:      r_erase_char      <= i_cfg_data;
                    CFG_KILL:       r_kill_char       <= i_cfg_data;
                    CFG_WORD_ERASE: r_word_erase_char <= i_cfg_data;
                    CFG_EOT:        r_eot_char        <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_p    <= n_p;
        r_n    <= n_n;
        r_i    <= n_i;
        r_pend <= n_pend;
        if (emit) begin
            r_out <= emit_res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.action      = r_out.action;
    assign o_res.char_value  = r_out.char_value;
    assign o_res.erase_count = r_out.erase_count;
    assign o_res.last        = r_out.last;

endmodule

FILE: tb/lewr_action_checker.sv
`timescale 1ns / 100ps

module lewr_action_checker import lewr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    lewr_in_if                   i_key,
    lewr_out_if                  i_res,
    output int                   o_pending,
    output int                   o_fail_count
);

    logic [CHAR_W-1:0] line_chars [LINE_WIDTH];
    int unsigned       col;
    logic              input_ended;
    logic [BYTE_W-1:0] erase_code;
    logic [BYTE_W-1:0] kill_code;
    logic [BYTE_W-1:0] word_code;
    logic [BYTE_W-1:0] eot_code;
    t_result           actions_due [$];
    t_result           key_actions [$];
    int                fails = 0;

    function automatic t_result make_action(t_action act, logic [BYTE_W-1:0] ch,
                                            logic [CNT_W-1:0] cnt);
        t_result r;
        r.action      = act;
        r.char_value  = ch;
        r.erase_count = cnt;
        r.last        = 1'b0;
        return r;
    endfunction

    // full line: carry the trailing word to a fresh line, or just break
    task automatic wrap_word();
        int unsigned p;
        int unsigned n;
        p = col;
        while (p > 0 && line_chars[p-1] != SPACE_CHAR)
            p--;
        if (p == 0) begin
            col = 0;
            key_actions.push_back(make_action(ACT_NEWLINE, NEWLINE_BYTE, '0));
        end else begin
            n = col - p;
            if (n > 0) begin
                key_actions.push_back(make_action(ACT_ERASE, '0, CNT_W'(n)));
                for (int i = 0; i < n; i++)
                    line_chars[i] = line_chars[p+i];
            end
            col = n;
            key_actions.push_back(make_action(ACT_NEWLINE, NEWLINE_BYTE, '0));
            for (int i = 0; i < n; i++)
                key_actions.push_back(make_action(ACT_ECHO, {1'b0, line_chars[i]}, '0));
        end
    endtask

    task automatic apply_key(logic [BYTE_W-1:0] b);
        int unsigned p;
        t_result     tail;
        key_actions.delete();
        if (!input_ended) begin
            if (b == NEWLINE_BYTE) begin
                key_actions.push_back(make_action(ACT_NEWLINE, NEWLINE_BYTE, '0));
                col = 0;
            end else if (b >= PRINT_LO && b <= PRINT_HI) begin
                key_actions.push_back(make_action(ACT_ECHO, b, '0));
                if (col < LINE_WIDTH) begin
                    line_chars[col] = b[CHAR_W-1:0];
                    col++;
                end
                if (col >= LINE_WIDTH)
                    wrap_word();
            end else if (b == erase_code) begin
                if (col > 0) begin
                    key_actions.push_back(make_action(ACT_ERASE, '0, CNT_W'(1)));
                    col--;
                end
            end else if (b == kill_code) begin
                if (col > 0) begin
                    key_actions.push_back(make_action(ACT_ERASE, '0, CNT_W'(col)));
                    col = 0;
                end
            end else if (b == word_code) begin
                p = col;
                while (p > 0 && line_chars[p-1] == SPACE_CHAR)
                    p--;
                while (p > 0 && line_chars[p-1] != SPACE_CHAR)
                    p--;
                if (p < col) begin
                    key_actions.push_back(make_action(ACT_ERASE, '0, CNT_W'(col - p)));
                    col = p;
                end
            end else if (b == eot_code) begin
                if (col == 0) begin
                    key_actions.push_back(make_action(ACT_END, '0, '0));
                    input_ended = 1'b1;
                end
            end else begin
                key_actions.push_back(make_action(ACT_BELL, '0, '0));
            end
        end
        if (key_actions.size() > 0) begin
            tail      = key_actions.pop_back();
            tail.last = 1'b1;
            key_actions.push_back(tail);
        end
        foreach (key_actions[i])
            actions_due.push_back(key_actions[i]);
    endtask

    task automatic report_mismatch(string what);
        fails++;
        $display("%0t ns: %s", $time, what);
    endtask

    task automatic check_beat();
        t_result due;
        if (actions_due.size() == 0) begin
            report_mismatch($sformatf("unexpected action beat, action %0d", i_res.action));
        end else begin
            due = actions_due.pop_front();
            if (i_res.action !== due.action)
                report_mismatch($sformatf("action %0d, wanted %0d", i_res.action, due.action));
            if (i_res.char_value !== due.char_value)
                report_mismatch($sformatf("char_value %0d, wanted %0d",
                                          i_res.char_value, due.char_value));
            if (i_res.erase_count !== due.erase_count)
                report_mismatch($sformatf("erase_count %0d, wanted %0d",
                                          i_res.erase_count, due.erase_count));
            if (i_res.last !== due.last)
                report_mismatch($sformatf("last %0b, wanted %0b", i_res.last, due.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            col         = 0;
            input_ended = 1'b0;
            erase_code  = ERASE_RST;
            kill_code   = KILL_RST;
            word_code   = WORD_ERASE_RST;
            eot_code    = EOT_RST;
            actions_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ERASE:      erase_code = i_cfg_data;
                    CFG_KILL:       kill_code  = i_cfg_data;
                    CFG_WORD_ERASE: word_code  = i_cfg_data;
                    CFG_EOT:        eot_code   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_key.valid && i_key.ready)
                apply_key(i_key.key_byte);
            if (i_res.valid && i_res.ready)
                check_beat();
        end
        o_pending    <= actions_due.size();
        o_fail_count <= fails;
    end

endmodule

FILE: tb/line_editor_word_wrap_test.sv
`timescale 1ns / 100ps

module line_editor_word_wrap_test import lewr_pkg::*; ();

    // longest quiet stretch the block may need after its last beat:
    // a full wrap, plus margin
    localparam int DRAIN_CYCLES = 120;
    // run limit, several times what the slowest correct run needs
    localparam int LIMIT_CYCLES = 400000;

    // register slots past the last real one, must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_EOT + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

    localparam logic [BYTE_W-1:0] SPACE_BYTE = BYTE_W'(SPACE_CHAR);

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [BYTE_W-1:0]    i_cfg_data;

    lewr_in_if  key_if ();
    lewr_out_if res_if ();

    int fail_count;
    int pending;
    int cycle_count = 0;
    int stall_left  = 0;
    bit gaps_on;
    bit stalls_on;

    // current control codes, so the stimulus can aim at each function
    logic [BYTE_W-1:0] erase_code;
    logic [BYTE_W-1:0] kill_code;
    logic [BYTE_W-1:0] word_code;
    logic [BYTE_W-1:0] eot_code;

    line_editor_word_wrap dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_key      (key_if),
        .o_res      (res_if)
    );

    lewr_action_checker action_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_key        (key_if),
        .i_res        (res_if),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // hard stop in case the block hangs or owes beats forever
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side back-pressure: ready drops in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left   <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (stalls_on && $urandom_range(4, 0) == 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= $urandom_range(4, 0);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // one key beat; valid stays high into the next beat unless a gap is taken
    task automatic send_key(logic [BYTE_W-1:0] b);
        if (gaps_on && $urandom_range(3, 0) == 0) begin
            key_if.valid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge i_clk);
        end
        key_if.valid    <= 1'b1;
        key_if.key_byte <= b;
        do @(posedge i_clk); while (!key_if.ready);
    endtask

    // random printable non-space characters, so no space inside a word
    task automatic type_word(int len);
        for (int i = 0; i < len; i++)
            send_key(BYTE_W'($urandom_range(PRINT_HI, PRINT_LO + 1)));
    endtask

    // write enable is left high so writes can run back to back
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic set_codes(logic [BYTE_W-1:0] erase_v, logic [BYTE_W-1:0] kill_v,
                             logic [BYTE_W-1:0] word_v, logic [BYTE_W-1:0] eot_v);
        cfg_write(CFG_ERASE, erase_v);
        cfg_write(CFG_KILL, kill_v);
        cfg_write(CFG_WORD_ERASE, word_v);
        cfg_write(CFG_EOT, eot_v);
        i_cfg_we   <= 1'b0;
        erase_code = erase_v;
        kill_code  = kill_v;
        word_code  = word_v;
        eot_code   = eot_v;
    endtask

    // hold the sender until every owed beat is in, then let the block go quiet
    task automatic settle();
        key_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic directed_keys();
        // bell on control bytes, all bits low and all bits high
        send_key(8'h00);
        send_key(8'hFF);
        send_key(8'h80);
        send_key(8'h1F);
        // nothing to erase on an empty line: no beats
        send_key(erase_code);
        send_key(kill_code);
        send_key(word_code);
        // printable range ends, then a word erase over a word, over a space,
        // then over a line of spaces only
        send_key(SPACE_BYTE);
        send_key(PRINT_HI);
        send_key("a");
        send_key("b");
        send_key(SPACE_BYTE);
        send_key("c");
        send_key(word_code);
        send_key(word_code);
        send_key(word_code);
        // end of transmission with text on the line is dropped
        send_key("x");
        send_key(eot_code);
        send_key(erase_code);
        send_key("y");
        send_key("z");
        send_key(kill_code);
        send_key("q");
        send_key(NEWLINE_BYTE);
        send_key(NEWLINE_BYTE);
    endtask

    // lines that run into the right margin
    task automatic full_lines();
        // one word longer than the line: plain break, last char on the next line
        send_key(NEWLINE_BYTE);
        type_word(LINE_WIDTH + 1);
        // long trailing word after a space: erase run, newline, echo of the word
        send_key(SPACE_BYTE);
        type_word(LINE_WIDTH - 2);
        // full line ending on a space: nothing to carry, just a newline
        type_word(1);
        send_key(SPACE_BYTE);
    endtask

    // mostly words and spaces so lines fill up, with edits and stray bytes
    task automatic random_typing(int n);
        int                sent;
        int                pick;
        int                len;
        logic [BYTE_W-1:0] noise;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(99, 0);
            if (pick < 55) begin
                len = $urandom_range(9, 1);
                type_word(len);
                sent += len;
                if ($urandom_range(3, 0) != 0) begin
                    send_key(SPACE_BYTE);
                    sent++;
                end
            end else if (pick < 60) begin
                send_key(NEWLINE_BYTE);
                sent++;
            end else if (pick < 70) begin
                send_key(erase_code);
                sent++;
            end else if (pick < 75) begin
                send_key(kill_code);
                sent++;
            end else if (pick < 85) begin
                send_key(word_code);
                sent++;
            end else begin
                noise = BYTE_W'($urandom_range(255, 0));
                // an end of transmission must not land on an empty line yet
                if (noise == eot_code) begin
                    send_key(NEWLINE_BYTE);
                    send_key("a");
                    sent += 2;
                end
                send_key(noise);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_ERASE;
        i_cfg_data      <= '0;
        key_if.valid    <= 1'b0;
        key_if.key_byte <= '0;
        erase_code = ERASE_RST;
        kill_code  = KILL_RST;
        word_code  = WORD_ERASE_RST;
        eot_code   = EOT_RST;
        gaps_on    = 1'b1;
        stalls_on  = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset codes
        directed_keys();
        settle();

        // extremes, margin cases first
        set_codes(8'd0, 8'd255, 8'd8, 8'd27);
        full_lines();
        random_typing(4);
        settle();

        // erase and kill share a code: erase wins
        stalls_on = 1'b0;
        set_codes(8'd8, 8'd8, 8'd255, 8'd0);
        random_typing(4);
        settle();

        // kill and word erase share a code: kill wins
        stalls_on = 1'b1;
        gaps_on   = 1'b0;
        set_codes(8'd255, 8'd0, 8'd0, 8'd255);
        random_typing(4);
        settle();

        // codes that collide with a printable and with newline lose to them
        gaps_on = 1'b1;
        set_codes("A", NEWLINE_BYTE, 8'd127, 8'd128);
        random_typing(4);
        settle();

        // last part: no idling on either side, spare slots written too
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        cfg_write(CFG_SPARE_LO, BYTE_W'($urandom_range(255, 0)));
        cfg_write(CFG_SPARE_HI, BYTE_W'($urandom_range(255, 0)));
        set_codes(ERASE_RST, KILL_RST, WORD_ERASE_RST, EOT_RST);
        random_typing(4);
        settle();

        // end of transmission on an empty line ends input for good
        send_key(NEWLINE_BYTE);
        send_key(eot_code);
        send_key("a");
        send_key(eot_code);
        send_key(8'hFF);
        settle();
        // registers still take writes after the end, keys still ignored
        set_codes(8'd0, 8'd255, 8'd0, 8'd255);
        send_key(8'h00);
        send_key("b");
        settle();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
